>>> design/plr_pkg.sv
// shared types and constants of the polyphase line resampler
package plr_pkg;

  localparam int MAX_TAPS_DEF   = 7;
  localparam int MAX_PHASES_DEF = 16;
  localparam int MAX_WIDTH_DEF  = 4096;

  localparam int OUT_SHIFT   = 5;
  localparam int PIX_MAX     = 8'hff;
  localparam int PIX_LIMIT   = 256;
  localparam int MAX_RESULTS = 64;
  localparam int MAX_DOWN    = 16;
  localparam int MAX_OUTW    = 65536;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] REG_INTERP    = 3'd0;
  localparam logic [2:0] REG_DECIM     = 3'd1;
  localparam logic [2:0] REG_TAP_COUNT = 3'd2;
  localparam logic [2:0] REG_LINE_LEN  = 3'd3;
  localparam logic [2:0] REG_OUT_LEN   = 3'd4;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_COEF  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        pixel;
    logic              line_end;
    logic [3:0]        coef_phase;
    logic [2:0]        coef_tap;
    logic signed [15:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_pixel;
    logic [15:0] out_position;
    logic        run_last;
    logic        line_last;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  interp;
    logic [4:0]  decim;
    logic [2:0]  tap_count;
    logic [12:0] line_len;
    logic [16:0] out_len;
  } cfg_t;

endpackage

>>> design/plr_ram.sv
// generic single-write, single-read ram with registered read data
module plr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 112
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/plr_queue.sv
// front end: accepts input items into a short queue ahead of the engine
module plr_queue #(
  parameter int DEPTH = plr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_stall,
  input  plr_pkg::in_item_t pix_item,
  output logic              head_valid,
  output plr_pkg::in_item_t head,
  input  logic              pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  plr_pkg::in_item_t slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic push;
  logic take;

  assign pix_stall  = (count == CW'(DEPTH));
  assign push       = pix_valid && !pix_stall;
  assign head_valid = (count != '0);
  assign take       = pop && head_valid;
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= pix_item;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (take) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/plr_engine.sv
// back end: coefficient store, pixel window and multiply-accumulate sequencer
module plr_engine #(
  parameter int MAX_TAPS   = plr_pkg::MAX_TAPS_DEF,
  parameter int MAX_PHASES = plr_pkg::MAX_PHASES_DEF,
  parameter int MAX_WIDTH  = plr_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  plr_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  plr_pkg::in_item_t  head,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output plr_pkg::out_item_t res_item
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int KW  = $clog2(MAX_WIDTH);
  localparam int PHW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int JW  = $clog2(MAX_TAPS + 1);
  localparam int WIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int AW  = $clog2(MAX_PHASES * MAX_TAPS);
  localparam int CW  = 21;
  localparam int SW  = CW + 2;
  localparam int TW  = 6;
  localparam int NW  = $clog2(plr_pkg::MAX_RESULTS + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PASS   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_MAC    = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_ADV    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;

  logic [7:0]        win [MAX_TAPS];
  logic [KW-1:0]     k;
  logic [16:0]       next_out;
  logic [PHW-1:0]    phase;
  logic [TW-1:0]     t;
  logic [CW-1:0]     center;
  logic              final_px;
  logic [NW-1:0]     n;
  logic [JW-1:0]     j;
  logic signed [31:0] acc;
  logic              s1_v;
  logic [7:0]        s1_pix;
  logic              s2_v;
  logic signed [24:0] prod;
  logic              pend_valid;
  logic [7:0]        pend_pixel;
  logic [15:0]       pend_pos;

  // saturated register values
  logic [WW-1:0] inw;
  logic [16:0]   outw;
  logic [4:0]    up;
  logic [4:0]    down;
  logic [2:0]    taps;
  logic [2:0]    hi;

  always_comb begin
    if (cfg.line_len == '0) begin
      inw = WW'(1);
    end else if (int'(cfg.line_len) > MAX_WIDTH) begin
      inw = WW'(MAX_WIDTH);
    end else begin
      inw = WW'(cfg.line_len);
    end
    if (cfg.out_len == '0) begin
      outw = 17'd1;
    end else if (int'(cfg.out_len) > plr_pkg::MAX_OUTW) begin
      outw = 17'(plr_pkg::MAX_OUTW);
    end else begin
      outw = cfg.out_len;
    end
    if (cfg.interp == '0) begin
      up = 5'd1;
    end else if (int'(cfg.interp) > MAX_PHASES) begin
      up = 5'(MAX_PHASES);
    end else begin
      up = cfg.interp;
    end
    if (cfg.decim == '0) begin
      down = 5'd1;
    end else if (int'(cfg.decim) > plr_pkg::MAX_DOWN) begin
      down = 5'(plr_pkg::MAX_DOWN);
    end else begin
      down = cfg.decim;
    end
    if (cfg.tap_count == '0) begin
      taps = 3'd1;
    end else if (int'(cfg.tap_count) > MAX_TAPS) begin
      taps = 3'(MAX_TAPS);
    end else begin
      taps = cfg.tap_count;
    end
    hi = taps - 3'd1 - (taps >> 1);
  end

  // source position of window slot j and its distance back from the newest pixel
  logic signed [SW-1:0] src_pos;
  logic signed [SW-1:0] src_dist;
  logic                 src_in;
  logic [WIW-1:0]       win_idx;

  always_comb begin
    src_pos  = $signed({2'b00, center}) + $signed(SW'(j)) - $signed(SW'(taps >> 1));
    src_dist = $signed(SW'(k)) - src_pos;
    src_in   = !src_pos[SW-1] && !src_dist[SW-1] && (src_dist < $signed(SW'(MAX_TAPS)));
    win_idx  = src_dist[WIW-1:0];
  end

  // coefficient store
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic          take;
  logic          is_coef;

  assign take    = head_valid && (state == S_IDLE);
  assign pop     = take;
  assign is_coef = (head.cmd == plr_pkg::CMD_COEF);

  assign ram_we    = take && is_coef && (int'(head.coef_phase) < MAX_PHASES)
                     && (int'(head.coef_tap) < MAX_TAPS);
  assign ram_waddr = AW'(int'(head.coef_phase) * MAX_TAPS + int'(head.coef_tap));
  assign ram_raddr = AW'(int'(phase) * MAX_TAPS + int'(taps) - 1 - int'(j));

  plr_ram #(
    .WIDTH (16),
    .DEPTH (MAX_PHASES * MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (head.coef_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic more;
  logic slot_free;
  logic emit;
  logic signed [31:0] q;
  logic [7:0] q_pix;

  assign more = (int'(n) < plr_pkg::MAX_RESULTS) && (next_out < outw)
                && (final_px || (int'(center) + int'(hi) <= int'(k)));
  assign slot_free = !res_valid || !res_stall;
  assign emit      = slot_free && ((state == S_PASS) || ((state == S_CHECK) && pend_valid));

  always_comb begin
    q = acc >>> plr_pkg::OUT_SHIFT;
    if (q >= plr_pkg::PIX_LIMIT) begin
      q_pix = 8'(plr_pkg::PIX_MAX);
    end else if (q < 0) begin
      q_pix = 8'd0;
    end else begin
      q_pix = q[7:0];
    end
  end

  // multiply-accumulate pipeline: pixel select, product, accumulate
  always_ff @(posedge clk) begin
    s1_pix <= src_in ? win[win_idx] : 8'd0;
    prod   <= $signed({1'b0, s1_pix}) * $signed(ram_rdata);
    if (state == S_CHECK) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + 32'(prod);
    end
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= (state == S_MAC);
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      k          <= '0;
      next_out   <= '0;
      phase      <= '0;
      t          <= '0;
      center     <= '0;
      final_px   <= 1'b0;
      n          <= '0;
      j          <= '0;
      pend_valid <= 1'b0;
      pend_pixel <= '0;
      pend_pos   <= '0;
      res_valid  <= 1'b0;
      res_item   <= '0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take && !is_coef) begin
            win[0] <= head.pixel;
            for (int i = 1; i < MAX_TAPS; i++) begin
              win[i] <= win[i-1];
            end
            final_px <= head.line_end || (int'(k) + 1 >= int'(inw));
            n        <= '0;
            state    <= (17'(inw) == outw) ? S_PASS : S_CHECK;
          end
        end
        S_PASS: begin
          if (slot_free) begin
            res_item.out_pixel     <= win[0];
            res_item.out_position  <= 16'(k);
            res_item.run_last      <= 1'b1;
            res_item.line_last     <= final_px;
            state                  <= S_FINISH;
          end
        end
        S_CHECK: begin
          if (!pend_valid || slot_free) begin
            if (pend_valid) begin
              res_item.out_pixel    <= pend_pixel;
              res_item.out_position <= pend_pos;
              res_item.run_last     <= !more;
              res_item.line_last    <= !more && final_px;
              pend_valid            <= 1'b0;
            end
            if (more) begin
              j     <= '0;
              state <= S_MAC;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_MAC: begin
          j <= j + 1'b1;
          if (j == JW'(taps - 3'd1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_v && !s2_v) begin
            pend_valid <= 1'b1;
            pend_pixel <= q_pix;
            pend_pos   <= next_out[15:0];
            n          <= n + 1'b1;
            next_out   <= next_out + 17'd1;
            t          <= TW'(phase) + TW'(down);
            state      <= S_ADV;
          end
        end
        S_ADV: begin
          // quotient of the phase step taken one subtraction a cycle
          if (t >= TW'(up)) begin
            t      <= t - TW'(up);
            center <= center + 1'b1;
          end else begin
            phase <= t[PHW-1:0];
            state <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (final_px) begin
            k        <= '0;
            next_out <= '0;
            phase    <= '0;
            center   <= '0;
            for (int i = 0; i < MAX_TAPS; i++) begin
              win[i] <= '0;
            end
          end else begin
            k <= k + 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/polyphase_line_resampler.sv
// top level of the polyphase line resampler: configuration registers and wiring
//
// Input channel pix_valid/pix_stall/pix_item carries pixel items (cmd 0) and
// coefficient load items (cmd 1); a transaction happens when valid is high
// and stall is low. Items enter a two-entry queue, so the next item is taken
// while the engine still works or a result waits on the output side.
// Results leave on res_valid/res_stall/res_item from an output register; a
// stalled result holds, and the engine waits for the register to free up.
// Configuration writes use cfg_valid/cfg_ready (ready is always high) with
// cfg_index selecting interpolation, decimation, taps, input and output length.
// Per item: a coefficient load is written in the idle state. A pixel when the
// line lengths match goes through the pass state, which registers its result.
// Otherwise a pixel goes, per output, through the decision state, the
// multiply-accumulate pipeline and the phase stepping; the shared multiplier
// and the stepping set its pace. The first result of a pixel is held in a
// pending register and moves to the output register in a later pass through
// the decision state, when that register is free.
// Synchronous reset empties the queue, clears the line state and the pixel
// window and restores register defaults; coefficients are undefined until loaded.
module polyphase_line_resampler #(
  parameter int MAX_TAPS   = plr_pkg::MAX_TAPS_DEF,
  parameter int MAX_PHASES = plr_pkg::MAX_PHASES_DEF,
  parameter int MAX_WIDTH  = plr_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  output logic               pix_stall,
  input  plr_pkg::in_item_t  pix_item,
  output logic               res_valid,
  input  logic               res_stall,
  output plr_pkg::out_item_t res_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  plr_pkg::cfg_t     cfg;
  logic              head_valid;
  plr_pkg::in_item_t head;
  logic              pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interp    <= 5'd1;
      cfg.decim     <= 5'd1;
      cfg.tap_count <= 3'd5;
      cfg.line_len  <= 13'd1;
      cfg.out_len   <= 17'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        plr_pkg::REG_INTERP:    cfg.interp    <= cfg_data[4:0];
        plr_pkg::REG_DECIM:     cfg.decim     <= cfg_data[4:0];
        plr_pkg::REG_TAP_COUNT: cfg.tap_count <= cfg_data[2:0];
        plr_pkg::REG_LINE_LEN:  cfg.line_len  <= cfg_data[12:0];
        plr_pkg::REG_OUT_LEN:   cfg.out_len   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  plr_queue #(
    .DEPTH (plr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_item   (pix_item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  plr_engine #(
    .MAX_TAPS   (MAX_TAPS),
    .MAX_PHASES (MAX_PHASES),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

endmodule

>>> sim/polyphase_line_resampler_tb.sv
// self-checking testbench of the polyphase line resampler
module polyphase_line_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_TAPS   = plr_pkg::MAX_TAPS_DEF;
  localparam int N_PHASES = plr_pkg::MAX_PHASES_DEF;
  localparam int STUCK_LIMIT = 20000;

  // line filter model with its own copy of registers, window and coefficients
  class resample_scoreboard;
    logic [4:0]  up_reg, down_reg;
    logic [2:0]  taps_reg;
    logic [12:0] inw_reg;
    logic [16:0] outw_reg;
    logic [7:0]  window [N_TAPS];
    logic signed [15:0] coefs [N_PHASES][N_TAPS];
    int unsigned seen, next_out, phase, center;
    plr_pkg::out_item_t awaited [$];
    int          errors;

    function void restart_line();
      foreach (window[j]) window[j] = '0;
      seen = 0; next_out = 0; phase = 0; center = 0;
    endfunction

    function void reset_regs();
      up_reg = 1; down_reg = 1; taps_reg = 5; inw_reg = 1; outw_reg = 1;
      errors = 0;
      foreach (coefs[p, t]) coefs[p][t] = '0;
      restart_line();
    endfunction

    function void write_reg(logic [2:0] idx, logic [16:0] data);
      case (idx)
        plr_pkg::REG_INTERP:    up_reg   = data[4:0];
        plr_pkg::REG_DECIM:     down_reg = data[4:0];
        plr_pkg::REG_TAP_COUNT: taps_reg = data[2:0];
        plr_pkg::REG_LINE_LEN:  inw_reg  = data[12:0];
        plr_pkg::REG_OUT_LEN:   outw_reg = data[16:0];
        default: ;
      endcase
    endfunction

    function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function logic [7:0] filter_pixel(int unsigned taps, int unsigned k);
      longint lo, p;
      int sum, q;
      logic [7:0] px;
      sum = 0;
      lo = longint'(center) - longint'(taps / 2);
      for (int j = 0; j < taps; j++) begin
        p = lo + j;
        if (p < 0 || p > k || longint'(k) - p >= N_TAPS) px = 0;
        else px = window[k - p];
        sum += int'(px) * int'(coefs[phase][taps - 1 - j]);
      end
      q = sum >>> plr_pkg::OUT_SHIFT;  // floor division by 32
      if (q >= plr_pkg::PIX_LIMIT) return 8'(plr_pkg::PIX_MAX);
      if (q < 0) return 8'd0;
      return q[7:0];
    endfunction

    function void note_input(plr_pkg::in_item_t it);
      int unsigned inw, outw, up, down, taps, hi, k, t, n;
      bit fin;
      plr_pkg::out_item_t r;
      if (it.cmd == plr_pkg::CMD_COEF) begin
        if (it.coef_tap < N_TAPS) coefs[it.coef_phase][it.coef_tap] = it.coef_value;
        return;
      end
      for (int j = N_TAPS - 1; j > 0; j--) window[j] = window[j - 1];
      window[0] = it.pixel;
      k = seen;
      inw = clip(inw_reg, 1, plr_pkg::MAX_WIDTH_DEF);
      outw = clip(outw_reg, 1, plr_pkg::MAX_OUTW);
      fin = it.line_end || (k + 1 >= inw);
      if (inw == outw) begin
        r.out_pixel = it.pixel; r.out_position = k[15:0];
        r.run_last = 1'b1; r.line_last = fin;
        awaited.push_back(r);
      end else begin
        up = clip(up_reg, 1, N_PHASES);
        down = clip(down_reg, 1, plr_pkg::MAX_DOWN);
        taps = clip(taps_reg, 1, N_TAPS);
        hi = (taps - 1) - taps / 2;
        n = 0;
        while (n < plr_pkg::MAX_RESULTS && next_out < outw && (fin || center + hi <= k)) begin
          r.out_pixel = filter_pixel(taps, k);
          r.out_position = next_out[15:0];
          r.run_last = 1'b0; r.line_last = 1'b0;
          awaited.push_back(r);
          n++; next_out++;
          t = phase + down;
          center += t / up;
          phase = t % up;
        end
        if (n > 0) begin
          awaited[$].run_last = 1'b1;
          awaited[$].line_last = fin;
        end
      end
      if (fin) restart_line();
      else seen = k + 1;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task check_result(plr_pkg::out_item_t got);
      plr_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        report("unexpected result at position", 32'(got.out_position), 32'd0);
        return;
      end
      want = awaited.pop_front();
      if (got.out_pixel != want.out_pixel)
        report($sformatf("out_pixel pos %0d", want.out_position),
               32'(got.out_pixel), 32'(want.out_pixel));
      if (got.out_position != want.out_position)
        report("out_position", 32'(got.out_position), 32'(want.out_position));
      if (got.run_last != want.run_last)
        report($sformatf("run_last pos %0d", want.out_position),
               32'(got.run_last), 32'(want.run_last));
      if (got.line_last != want.line_last)
        report($sformatf("line_last pos %0d", want.out_position),
               32'(got.line_last), 32'(want.line_last));
    endtask
  endclass

  logic clk, rst;
  logic pix_valid, pix_stall, res_valid, res_stall, cfg_valid, cfg_ready;
  plr_pkg::in_item_t  pix_item;
  plr_pkg::out_item_t res_item;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  resample_scoreboard sb;
  int  burst_left;
  bit  hold_req;
  int  hold_left, stall_mode, stall_tick, idle_cycles;

  polyphase_line_resampler i_dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_item(pix_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // result side: check each transaction, stall on a changing pattern
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res_item);
    if (hold_req && hold_left == 0) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 9) < 7);
        default: res_stall <= (stall_tick % 5 < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall)
        || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(plr_pkg::in_item_t it);
    pix_item <= it;
    pix_valid <= 1'b1;
    do @(posedge clk); while (pix_stall);
    sb.note_input(it);
    if (burst_left > 0) burst_left--;
    else begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(0, 12);
    end
  endtask

  // hold the input side until every expected result is out, then let the engine settle
  task automatic drain();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(int up, int down, int taps, int inw, int outw);
    drain();
    // stray upper bits must be ignored by the narrower registers
    write_reg(plr_pkg::REG_INTERP, 17'(up) | 17'($urandom() << 5));
    write_reg(plr_pkg::REG_DECIM, 17'(down) | 17'($urandom() << 5));
    write_reg(plr_pkg::REG_TAP_COUNT, 17'(taps) | 17'($urandom() << 3));
    write_reg(plr_pkg::REG_LINE_LEN, 17'(inw) | 17'($urandom() << 13));
    write_reg(plr_pkg::REG_OUT_LEN, 17'(outw));
  endtask

  function automatic plr_pkg::in_item_t coef_item(int ph, int tp, int val);
    plr_pkg::in_item_t it;
    it = plr_pkg::in_item_t'(33'({$urandom(), $urandom()}));
    it.cmd = plr_pkg::CMD_COEF;
    it.coef_phase = ph[3:0];
    it.coef_tap = tp[2:0];
    it.coef_value = val[15:0];
    return it;
  endfunction

  function automatic plr_pkg::in_item_t pixel_item(int px, bit last);
    plr_pkg::in_item_t it;
    it = plr_pkg::in_item_t'(33'({$urandom(), $urandom()}));
    it.cmd = plr_pkg::CMD_PIXEL;
    it.pixel = px[7:0];
    it.line_end = last;
    return it;
  endfunction

  function automatic int random_coef();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 65535) - 32768;
      default: return $urandom_range(0, 100) - 30;
    endcase
  endfunction

  task automatic random_items(int count);
    int px;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(coef_item($urandom_range(0, 15), $urandom_range(0, 7), random_coef()));
      else begin
        case ($urandom_range(0, 7))
          0: px = 0;
          1: px = 255;
          default: px = $urandom_range(0, 255);
        endcase
        send_item(pixel_item(px, $urandom_range(0, 9) == 0));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    rst = 1'b1;
    pix_valid = 1'b0; pix_item = '0;
    res_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    burst_left = 0; hold_req = 1'b0; hold_left = 0;
    stall_mode = 0; stall_tick = 0; idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole coefficient store so that no unwritten entry is ever read
    for (int p = 0; p < N_PHASES; p++)
      for (int t = 0; t < N_TAPS; t++)
        send_item(coef_item(p, t, $urandom_range(0, 80) - 20));

    // directed: reset widths are equal, so pixels pass straight through
    send_item(pixel_item(0, 1'b0));
    send_item(pixel_item(255, 1'b1));
    set_mode(3, 2, 5, 12, 18);
    send_item(coef_item(0, 2, 32767));
    send_item(coef_item(0, 7, -32768));  // tap beyond the store is ignored
    for (int i = 0; i < 6; i++) send_item(pixel_item(255, 1'b0));
    send_item(pixel_item(0, 1'b1));
    send_item(coef_item(0, 2, -32768));
    for (int i = 0; i < 5; i++) send_item(pixel_item(255, i == 4));
    // line ends on in_width with more outputs left to flush
    for (int i = 0; i < 12; i++) send_item(pixel_item(i * 20, 1'b0));

    set_mode(3, 2, 5, 12, 18);
    random_items(30);
    set_mode(1, 3, 3, 30, 10);
    random_items(30);
    set_mode(16, 1, 7, 4, 64);
    random_items(25);
    set_mode(0, 0, 0, 0, 0);
    random_items(20);
    set_mode(31, 31, 7, 8191, 131071);
    hold_req = 1'b1;  // long output hold while input keeps flowing
    random_items(30);
    set_mode(4, 1, 1, 8, 8);
    random_items(30);
    set_mode(5, 7, 4, 20, 9);
    random_items(30);
    set_mode(2, 1, 6, 16, 32);
    random_items(30);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
design/plr_pkg.sv
design/plr_ram.sv
design/plr_queue.sv
design/plr_engine.sv
design/polyphase_line_resampler.sv
sim/polyphase_line_resampler_tb.sv
